/* rtl/core/sdt_section_parser_unit_assert.svh */
// Assertion macros for the section parser RTL.
`ifndef SDT_SECTION_PARSER_UNIT_ASSERT_SVH
`define SDT_SECTION_PARSER_UNIT_ASSERT_SVH

// An implication checked at every clock edge outside reset.
`define SDT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define SDT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/sdt_pkg.sv */
package sdt_pkg;

	localparam int unsigned MinSectionBytes = 15;
	localparam int unsigned MaxSectionBytes = 1024;
	localparam logic [31:0] CrcPoly = 32'h04C1_1DB7;
	localparam logic [12:0] FixedHeaderBytes = 13'd12;
	localparam logic [12:0] ServiceHeaderBytes = 13'd5;

	// Record kinds.
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_SERVICE = 2'd1;
	localparam logic [1:0] KIND_DESC = 2'd2;
	localparam logic [1:0] KIND_END = 2'd3;

	// End record status codes.
	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_CRC = 2'd1;
	localparam logic [1:0] STATUS_SIZE = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_ACTUAL_TID = 2'd0;
	localparam logic [1:0] REG_OTHER_TID = 2'd1;
	localparam logic [1:0] REG_SERVICE_LIMIT = 2'd2;
	localparam logic [1:0] REG_DESC_LIMIT = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [15:0] id_value;
		logic [15:0] network_or_length;
		logic [4:0]  version_or_running;
		logic [7:0]  sec_index;
		logic [7:0]  last_sec_index;
		logic [2:0]  flag_bits;
		logic [7:0]  aux_value;
		logic [9:0]  descriptor_offset;
		logic [1:0]  parse_status;
		logic [31:0] crc_computed;
		logic [31:0] crc_received;
	} out_item_t;

	typedef struct packed {
		logic [7:0] actual_table_id;
		logic [7:0] other_table_id;
		logic [7:0] service_limit;
		logic [6:0] descriptor_limit;
	} cfg_t;

	// One byte through the MSB-first CRC-32.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {b, 24'd0};
		for (int i = 0; i < 8; i++) begin
			c = c[31] ? ((c << 1) ^ CrcPoly) : (c << 1);
		end
		return c;
	endfunction

endpackage

/* rtl/core/sdt_section_parser_unit.sv */
// Service description section parser. One section byte is taken per clock
// cycle, back to back, while the input is not stalled; each byte passes the
// input register and then the result register and yields at most one record:
// a header, service, descriptor or end-of-section record carrying the CRC-32
// check. The rate, one byte per cycle when not stalled, comes from the
// bytewise CRC and field update between the two registers. A stall on the
// result side holds both registers; in_stall rises only while both are full.
module sdt_section_parser_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  sdt_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output sdt_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);
	import sdt_pkg::*;

	`include "sdt_section_parser_unit_assert.svh"

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      full_s1;
	logic      step;
	logic      rec_valid;
	out_item_t rec;
	logic      out_free;

	assign cfg_ready = 1'b1;
	assign out_free = !out_valid || !out_stall;
	assign step = full_s1 && out_free;
	assign in_stall = full_s1 && !out_free;

	sdt_cfg_regs u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid && cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
	);

	sdt_parse_core u_core (
		.clk(clk), .arst_n(arst_n), .step(step), .item_s1(item_s1), .cfg(cfg),
		.rec_valid(rec_valid), .rec(rec)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) full_s1 <= 1'b0;
		else if (!in_stall) full_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) item_s1 <= in_data;
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (out_free) out_valid <= step && rec_valid;
	end

	always_ff @(posedge clk) begin
		if (step && rec_valid) out_data <= rec;
	end

	`SDT_ASSERT_IMP(a_stall_only_full, in_stall, full_s1 && out_valid,
		"input stalled while a register is free")
	`SDT_ASSERT_NEXT(a_end_record, step && item_s1.last_byte,
		out_valid && out_data.record_kind == KIND_END, "last byte gave no end record")
	`SDT_ASSERT_NEXT(a_held_result, out_valid && out_stall,
		out_valid && $stable(out_data), "stalled result changed")

endmodule

/* rtl/core/sdt_cfg_regs.sv */
module sdt_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	input  logic [1:0]      cfg_index,
	input  logic [7:0]      cfg_data,
	output sdt_pkg::cfg_t   cfg
);
	import sdt_pkg::*;

	// Register file, written one register per transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.actual_table_id <= 8'd66;
			cfg.other_table_id <= 8'd70;
			cfg.service_limit <= 8'd64;
			cfg.descriptor_limit <= 7'd16;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ACTUAL_TID: cfg.actual_table_id <= cfg_data;
				REG_OTHER_TID: cfg.other_table_id <= cfg_data;
				REG_SERVICE_LIMIT: cfg.service_limit <= cfg_data;
				REG_DESC_LIMIT: cfg.descriptor_limit <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

endmodule

/* rtl/core/sdt_parse_core.sv */
module sdt_parse_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  sdt_pkg::in_item_t item_s1,
	input  sdt_pkg::cfg_t     cfg,
	output logic              rec_valid,
	output sdt_pkg::out_item_t rec
);
	import sdt_pkg::*;

	typedef enum logic [11:0] {
		PH_TID   = 12'b0000_0000_0001,
		PH_HDR   = 12'b0000_0000_0010,
		PH_SVC0  = 12'b0000_0000_0100,
		PH_SVC1  = 12'b0000_0000_1000,
		PH_SVC2  = 12'b0000_0001_0000,
		PH_SVC3  = 12'b0000_0010_0000,
		PH_SVC4  = 12'b0000_0100_0000,
		PH_DTAG  = 12'b0000_1000_0000,
		PH_DLEN  = 12'b0001_0000_0000,
		PH_DBODY = 12'b0010_0000_0000,
		PH_DSKIP = 12'b0100_0000_0000,
		PH_IDLE  = 12'b1000_0000_0000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [10:0] count_q, count_d;
	logic [11:0] decl_len_q, decl_len_d;
	logic [12:0] svc_left_q, svc_left_d;
	logic [11:0] desc_left_q, desc_left_d;
	logic [7:0]  svc_seen_q, svc_seen_d;
	logic [6:0]  desc_seen_q, desc_seen_d;
	logic [47:0] field_q, field_d;
	logic [31:0] crc_q, crc_d;
	logic [31:0] tail_q, tail_d;
	logic        syn_ok_q, syn_ok_d;
	logic [7:0]  table_q, table_d;
	logic        syn_bit_q, syn_bit_d;
	logic [15:0] stream_q, stream_d;
	logic [7:0]  tag_q, tag_d;
	logic [9:0]  doff_q, doff_d;
	logic [12:0] skip_q, skip_d;

	logic [7:0]  b;
	logic [47:0] shifted;
	logic        emit;
	out_item_t   o;
	logic [11:0] dll;
	logic [12:0] left;
	logic [12:0] dsum;
	logic [12:0] dafter;
	logic [10:0] size;

	assign b = item_s1.data_byte;
	assign shifted = {field_q[39:0], b};
	assign dll = {shifted[11:8], b};
	assign left = svc_left_q - ServiceHeaderBytes;
	assign dsum = {5'd0, b} + 13'd2;
	assign dafter = {1'b0, desc_left_q} - dsum;
	assign size = count_q + 11'd1;

	// Parse step for the byte held in the input register.
	always_comb begin
		phase_t nsvc;
		phase_d = phase_q; count_d = count_q; decl_len_d = decl_len_q;
		svc_left_d = svc_left_q; desc_left_d = desc_left_q; svc_seen_d = svc_seen_q;
		desc_seen_d = desc_seen_q; field_d = field_q; crc_d = crc_q;
		syn_ok_d = syn_ok_q; table_d = table_q; syn_bit_d = syn_bit_q;
		stream_d = stream_q; tag_d = tag_q; doff_d = doff_q; skip_d = skip_q;
		emit = 1'b0;
		o = '0;
		nsvc = PH_IDLE;
		if (count_q >= 11'd4) crc_d = crc_byte(crc_q, tail_q[31:24]);
		tail_d = {tail_q[23:0], b};
		unique case (phase_q)
			PH_TID: begin
				table_d = b;
				phase_d = (b == cfg.actual_table_id || b == cfg.other_table_id)
					? PH_HDR : PH_IDLE;
			end
			PH_HDR: begin
				field_d = shifted;
				if (count_q == 11'd1) begin
					syn_bit_d = b[7];
				end else if (count_q == 11'd2) begin
					decl_len_d = shifted[11:0];
					if (shifted[11:0] < 12'(MinSectionBytes - 3)
						|| shifted[11:0] > 12'(MaxSectionBytes - 3)) phase_d = PH_IDLE;
				end else if (count_q == 11'd4) begin
					stream_d = shifted[15:0];
				end else if (count_q == 11'd7) begin
					if (shifted[15:8] > shifted[7:0]) phase_d = PH_IDLE;
					else syn_ok_d = 1'b1;
				end else if (count_q >= 11'd10) begin
					emit = 1'b1;
					o.record_kind = KIND_HEADER;
					o.id_value = stream_q;
					o.network_or_length = shifted[23:8];
					o.version_or_running = shifted[45:41];
					o.sec_index = shifted[39:32];
					o.last_sec_index = shifted[31:24];
					o.flag_bits = {1'b0, syn_bit_q, shifted[40]};
					o.aux_value = table_q;
					svc_left_d = {1'b0, decl_len_q} - FixedHeaderBytes;
					svc_seen_d = 8'd0;
					phase_d = (svc_left_d >= ServiceHeaderBytes && cfg.service_limit != 8'd0)
						? PH_SVC0 : PH_IDLE;
				end
			end
			PH_SVC0: begin field_d = shifted; phase_d = PH_SVC1; end
			PH_SVC1: begin field_d = shifted; phase_d = PH_SVC2; end
			PH_SVC2: begin field_d = shifted; phase_d = PH_SVC3; end
			PH_SVC3: begin field_d = shifted; phase_d = PH_SVC4; end
			PH_SVC4: begin
				field_d = shifted;
				emit = 1'b1;
				o.record_kind = KIND_SERVICE;
				o.id_value = shifted[39:24];
				o.network_or_length = {4'd0, dll};
				o.version_or_running = {2'd0, shifted[15:13]};
				o.flag_bits = {shifted[12], shifted[16], shifted[17]};
				o.aux_value = svc_seen_q;
				svc_seen_d = svc_seen_q + 8'd1;
				if (dll == 12'd0) begin
					svc_left_d = left;
				end else if ({1'b0, dll} <= left) begin
					svc_left_d = left - {1'b0, dll};
					desc_left_d = dll;
					desc_seen_d = 7'd0;
				end else begin
					svc_left_d = 13'd0;
				end
				nsvc = (svc_left_d >= ServiceHeaderBytes && svc_seen_d < cfg.service_limit)
					? PH_SVC0 : PH_IDLE;
				if (dll == 12'd0) begin
					phase_d = nsvc;
				end else if ({1'b0, dll} <= left) begin
					if (dll >= 12'd2 && cfg.descriptor_limit != 7'd0) begin
						phase_d = PH_DTAG;
					end else begin
						skip_d = {1'b0, dll}; desc_left_d = 12'd0; phase_d = PH_DSKIP;
					end
				end else begin
					skip_d = left; desc_left_d = 12'd0;
					phase_d = (left != 13'd0) ? PH_DSKIP : nsvc;
				end
			end
			PH_DTAG: begin
				tag_d = b;
				doff_d = count_q[9:0];
				phase_d = PH_DLEN;
			end
			PH_DLEN: begin
				nsvc = (svc_left_q >= ServiceHeaderBytes && svc_seen_q < cfg.service_limit)
					? PH_SVC0 : PH_IDLE;
				if (dsum <= {1'b0, desc_left_q}) begin
					emit = 1'b1;
					o.record_kind = KIND_DESC;
					o.id_value = {8'd0, tag_q};
					o.network_or_length = {8'd0, b};
					o.aux_value = {1'b0, desc_seen_q};
					o.descriptor_offset = doff_q;
					desc_seen_d = desc_seen_q + 7'd1;
					if (dafter >= 13'd2 && desc_seen_d < cfg.descriptor_limit) begin
						desc_left_d = dafter[11:0];
						skip_d = {5'd0, b};
						phase_d = (b == 8'd0) ? PH_DTAG : PH_DBODY;
					end else begin
						skip_d = {5'd0, b} + dafter;
						desc_left_d = 12'd0;
						phase_d = (skip_d != 13'd0) ? PH_DSKIP : nsvc;
					end
				end else begin
					skip_d = {1'b0, desc_left_q} - 13'd2;
					desc_left_d = 12'd0;
					phase_d = (skip_d != 13'd0) ? PH_DSKIP : nsvc;
				end
			end
			PH_DBODY: begin
				skip_d = skip_q - 13'd1;
				if (skip_d == 13'd0) phase_d = PH_DTAG;
			end
			PH_DSKIP: begin
				skip_d = skip_q - 13'd1;
				if (skip_d == 13'd0)
					phase_d = (svc_left_q >= ServiceHeaderBytes
						&& svc_seen_q < cfg.service_limit) ? PH_SVC0 : PH_IDLE;
			end
			PH_IDLE: ;
			default: phase_d = PH_IDLE;
		endcase

		if (item_s1.last_byte) begin
			emit = 1'b1;
			o = '0;
			o.record_kind = KIND_END;
			o.id_value = {8'd0, svc_seen_d};
			o.crc_computed = crc_d;
			o.crc_received = syn_ok_d ? tail_d : 32'd0;
			if (size < 11'(MinSectionBytes) || size > 11'(MaxSectionBytes))
				o.parse_status = STATUS_SIZE;
			else
				o.parse_status = (crc_d != o.crc_received) ? STATUS_CRC : STATUS_OK;
		end else if (count_q < 11'(MaxSectionBytes)) begin
			count_d = count_q + 11'd1;
		end
	end

	// Section state; the end of a section returns it to its reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TID; count_q <= '0; decl_len_q <= '0; svc_left_q <= '0;
			desc_left_q <= '0; svc_seen_q <= '0; desc_seen_q <= '0; field_q <= '0;
			crc_q <= '1; tail_q <= '0; syn_ok_q <= 1'b0; table_q <= '0;
			syn_bit_q <= 1'b0; stream_q <= '0; tag_q <= '0; doff_q <= '0; skip_q <= '0;
		end else if (step && item_s1.last_byte) begin
			phase_q <= PH_TID; count_q <= '0; decl_len_q <= '0; svc_left_q <= '0;
			desc_left_q <= '0; svc_seen_q <= '0; desc_seen_q <= '0; field_q <= '0;
			crc_q <= '1; tail_q <= '0; syn_ok_q <= 1'b0; table_q <= '0;
			syn_bit_q <= 1'b0; stream_q <= '0; tag_q <= '0; doff_q <= '0; skip_q <= '0;
		end else if (step) begin
			phase_q <= phase_d; count_q <= count_d; decl_len_q <= decl_len_d;
			svc_left_q <= svc_left_d; desc_left_q <= desc_left_d;
			svc_seen_q <= svc_seen_d; desc_seen_q <= desc_seen_d; field_q <= field_d;
			crc_q <= crc_d; tail_q <= tail_d; syn_ok_q <= syn_ok_d; table_q <= table_d;
			syn_bit_q <= syn_bit_d; stream_q <= stream_d; tag_q <= tag_d;
			doff_q <= doff_d; skip_q <= skip_d;
		end
	end

	assign rec_valid = emit;
	assign rec = o;

endmodule
